FILE: src/shrng_pkg.sv
`default_nettype none
package shrng_pkg;

  localparam int GEN_W = 31;
  localparam int CNT_W = 32;

  typedef logic [GEN_W-1:0] gen_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [14:0]      PM_MULT     = 15'd16807;
  localparam logic [GEN_W-1:0] PM_MOD      = 31'h7FFF_FFFF;
  localparam logic [GEN_W-1:0] SEED_CAP    = 31'd2147383646;
  localparam logic [CNT_W-1:0] LIMIT_RESET = 32'd400000000;

  localparam int DEF_TABLE_DEPTH  = 32;
  localparam int DEF_WARMUP_EXTRA = 8;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_SEED = 1'b1;

endpackage
`default_nettype wire

FILE: src/shuffled_minimal_standard_rng_core.sv
`default_nettype none
// Channel  Direction  Handshake          Word
// in       input      in_valid/in_ready  in_operation, in_seed_value
// out      output     out_valid/out_ready out_random_value, out_limit_reached
// cfg      input      cfg_wr_en          cfg_wr_data (max_draws)
//
// Draw: count check, slot divide, table read, write-back, output load;
// only count check and output load when over the limit.
// Reseed: TABLE_DEPTH+WARMUP_EXTRA generator steps, one after another;
// no word is produced.
// Reset is synchronous; table contents are not cleared.
// A result waits in the output register while the next word is accepted.
module shuffled_minimal_standard_rng_core #(
  parameter int TABLE_DEPTH  = shrng_pkg::DEF_TABLE_DEPTH,
  parameter int WARMUP_EXTRA = shrng_pkg::DEF_WARMUP_EXTRA
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_operation,
  input  wire logic [31:0]      in_seed_value,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output shrng_pkg::gen_t       out_random_value,
  output logic                  out_limit_reached,
  input  wire logic             cfg_wr_en,
  input  wire shrng_pkg::cnt_t  cfg_wr_data
);
  import shrng_pkg::*;

  localparam int IW    = $clog2(TABLE_DEPTH);
  localparam int STEPS = TABLE_DEPTH + WARMUP_EXTRA;
  localparam int KW    = $clog2(STEPS);
  localparam logic [KW-1:0] K_FIRST = KW'(STEPS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DCHK  = 3'd1;
  localparam logic [2:0] S_DWAIT = 3'd2;
  localparam logic [2:0] S_DWR   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam logic [2:0] S_SINIT = 3'd5;
  localparam logic [2:0] S_SSTEP = 3'd6;

  logic [2:0]    state_r, state_nxt;
  gen_t          seed_r, seed_nxt;
  gen_t          gen_r, gen_nxt;
  gen_t          last_r, last_nxt;
  cnt_t          cnt_r, cnt_nxt;
  cnt_t          max_r;
  logic [KW-1:0] k_r, k_nxt;
  gen_t          res_val_r, res_val_nxt;
  logic          res_flag_r, res_flag_nxt;
  logic          out_valid_r, out_valid_nxt;
  gen_t          out_val_r, out_val_nxt;
  logic          out_flag_r, out_flag_nxt;

  logic          pm_start;
  gen_t          pm_in;
  logic          pm_done;
  gen_t          pm_res;
  logic          idx_start;
  logic          idx_done;
  logic [IW-1:0] idx_res;

  logic          ram_en;
  logic          ram_we;
  logic [IW-1:0] ram_addr;
  gen_t          ram_wdata;
  gen_t          ram_rdata;

  cnt_t          cnt_inc;
  gen_t          seed_fix;

  assign cnt_inc  = (cnt_r == '1) ? cnt_r : cnt_r + 32'd1;
  assign seed_fix = (seed_r == '0 || seed_r > SEED_CAP) ? GEN_W'(1) : seed_r;

  shrng_pm u_pm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pm_start),
    .g     (pm_in),
    .done  (pm_done),
    .res   (pm_res)
  );

  shrng_idx #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_idx (
    .clk   (clk),
    .rst_n (rst_n),
    .start (idx_start),
    .x     (last_r),
    .done  (idx_done),
    .idx   (idx_res)
  );

  shrng_ram #(
    .WIDTH (GEN_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // One item at a time: the read and write-back of a slot never overlap
  // with another access to the table.
  always_comb begin
    state_nxt     = state_r;
    seed_nxt      = seed_r;
    gen_nxt       = gen_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    res_val_nxt   = res_val_r;
    res_flag_nxt  = res_flag_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_flag_nxt  = out_flag_r;
    pm_start      = 1'b0;
    pm_in         = gen_r;
    idx_start     = 1'b0;
    ram_en        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = idx_res;
    ram_wdata     = gen_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_SEED) begin
            seed_nxt  = in_seed_value[GEN_W-1:0];
            state_nxt = S_SINIT;
          end else begin
            state_nxt = S_DCHK;
          end
        end
      end
      S_DCHK: begin
        cnt_nxt = cnt_inc;
        if (max_r != '0 && cnt_inc > max_r) begin
          res_val_nxt  = '0;
          res_flag_nxt = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          pm_start  = 1'b1;
          pm_in     = gen_r;
          idx_start = 1'b1;
          state_nxt = S_DWAIT;
        end
      end
      S_DWAIT: begin
        // generator result is ready before the slot index
        if (idx_done) begin
          gen_nxt   = pm_res;
          ram_en    = 1'b1;
          ram_addr  = idx_res;
          state_nxt = S_DWR;
        end
      end
      S_DWR: begin
        ram_en       = 1'b1;
        ram_we       = 1'b1;
        ram_addr     = idx_res;
        ram_wdata    = gen_r;
        last_nxt     = ram_rdata;
        res_val_nxt  = ram_rdata;
        res_flag_nxt = 1'b0;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_flag_nxt  = res_flag_r;
          state_nxt     = S_IDLE;
        end
      end
      S_SINIT: begin
        pm_start  = 1'b1;
        pm_in     = seed_fix;
        k_nxt     = K_FIRST;
        state_nxt = S_SSTEP;
      end
      S_SSTEP: begin
        if (pm_done) begin
          // last TABLE_DEPTH values fill the table from the top slot down
          if (32'(k_r) < 32'(TABLE_DEPTH)) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = k_r[IW-1:0];
            ram_wdata = pm_res;
          end
          if (k_r == '0) begin
            gen_nxt   = pm_res;
            last_nxt  = pm_res;
            state_nxt = S_IDLE;
          end else begin
            k_nxt    = k_r - KW'(1);
            pm_start = 1'b1;
            pm_in    = pm_res;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gen_r       <= GEN_W'(1);
      last_r      <= '0;
      cnt_r       <= '0;
      max_r       <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gen_r       <= gen_nxt;
      last_r      <= last_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    seed_r     <= seed_nxt;
    k_r        <= k_nxt;
    res_val_r  <= res_val_nxt;
    res_flag_r <= res_flag_nxt;
    out_val_r  <= out_val_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_random_value  = out_val_r;
  assign out_limit_reached = out_flag_r;

endmodule
`default_nettype wire

FILE: src/shrng_ram.sv
`default_nettype none
module shrng_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/shrng_pm.sv
`default_nettype none
// Park-Miller step: 16807 * g mod (2^31 - 1).
module shrng_pm (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire shrng_pkg::gen_t   g,
  output logic                   done,
  output shrng_pkg::gen_t        res
);
  import shrng_pkg::*;

  logic [45:0] prod_r;
  logic        v1_r;
  logic        done_r;
  gen_t        res_r;
  logic [31:0] fold;
  logic [31:0] fold_red;

  // Mersenne fold: hi + lo stays below 2M, one subtract is enough
  assign fold     = 32'(prod_r[45:31]) + 32'(prod_r[30:0]);
  assign fold_red = (fold >= 32'(PM_MOD)) ? fold - 32'(PM_MOD) : fold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      done_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= 46'(g) * 46'(PM_MULT);
    end
    if (v1_r) begin
      res_r <= fold_red[30:0];
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

FILE: src/shrng_idx.sv
`default_nettype none
// Shuffle slot = x / ((2^31-2)/DEPTH + 1), clamped. Reciprocal estimate is
// exact or one high; a back-multiply corrects it.
module shrng_idx #(
  parameter int TABLE_DEPTH = shrng_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire shrng_pkg::gen_t                x,
  output logic                                done,
  output logic [$clog2(TABLE_DEPTH)-1:0]      idx
);
  import shrng_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [31:0] DIVISOR =
    32'((64'h7FFF_FFFE / 64'(TABLE_DEPTH)) + 64'd1);
  localparam logic [31:0] RECIP =
    32'((64'h8000_0000 / 64'(DIVISOR)) + 64'd1);
  localparam int RW = $clog2(64'(RECIP) + 64'd1);
  localparam int PW = GEN_W + RW;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  logic [PW-1:0] prod_r;
  logic [PW-1:0] chk_r;
  logic [RW-1:0] qe_r;
  gen_t          x1_r;
  gen_t          x2_r;
  logic          v1_r;
  logic          v2_r;
  logic          done_r;
  logic [IW-1:0] idx_r;
  logic [RW-1:0] q_est;
  logic [RW-1:0] q_fix;

  assign q_est = prod_r[PW-1:GEN_W];
  assign q_fix = (chk_r > PW'(x2_r)) ? qe_r - RW'(1) : qe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= PW'(x) * PW'(RECIP);
      x1_r   <= x;
    end
    if (v1_r) begin
      chk_r <= PW'(q_est) * PW'(DIVISOR);
      qe_r  <= q_est;
      x2_r  <= x1_r;
    end
    if (v2_r) begin
      idx_r <= (32'(q_fix) >= 32'(TABLE_DEPTH)) ? LAST_IDX : IW'(q_fix);
    end
  end

  assign done = done_r;
  assign idx  = idx_r;

endmodule
`default_nettype wire

FILE: tb/sv/shuffled_minimal_standard_rng_core_tb.sv
`default_nettype none
module shuffled_minimal_standard_rng_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import shrng_pkg::*;

  localparam int DEPTH       = DEF_TABLE_DEPTH;
  localparam int WARMUP      = DEF_WARMUP_EXTRA;
  localparam int SETTLE      = 120;   // settle wait, longer than a reseed
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic        op;
    logic [31:0] seed;
  } rng_word_t;

  typedef struct packed {
    gen_t value;
    logic flagged;
  } draw_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = OP_DRAW;
  logic [31:0] in_seed_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  gen_t        out_random_value;
  logic        out_limit_reached;
  logic        cfg_wr_en = 1'b0;
  cnt_t        cfg_wr_data = '0;

  // generator model state
  gen_t gen_state = gen_t'(1);
  gen_t slots[DEPTH];
  gen_t last_pick = '0;
  cnt_t draw_total = '0;
  cnt_t draw_limit = LIMIT_RESET;

  rng_word_t    words_to_send[$];
  draw_result_t draws_due[$];

  bit steady_phase = 1'b0;
  int errors = 0;
  int words_sent = 0;
  int reseeds_sent = 0;
  int draws_checked = 0;
  int flagged_seen = 0;
  int cycle_count = 0;
  int hold_left = 0;

  shuffled_minimal_standard_rng_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_seed_value    (in_seed_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value),
    .out_limit_reached(out_limit_reached),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #10 clk = ~clk;

  function automatic gen_t park_miller_next(gen_t g);
    bit [63:0] wide;
    bit [63:0] prod;
    bit [63:0] rem;
    wide = g;
    prod = wide * PM_MULT;
    rem = prod % PM_MOD;
    return rem[GEN_W-1:0];
  endfunction

  task automatic reseed_table(logic [31:0] seed);
    gen_t g;
    g = seed[GEN_W-1:0];
    if (g == '0 || g > SEED_CAP) begin
      g = gen_t'(1);
    end
    for (int k = DEPTH + WARMUP - 1; k >= 0; k--) begin
      g = park_miller_next(g);
      if (k < DEPTH) begin
        slots[k] = g;
      end
    end
    gen_state = g;
    last_pick = slots[0];
  endtask

  // one accepted word through the generator model
  task automatic step_rng_model(rng_word_t w);
    draw_result_t res;
    int unsigned slot_div;
    int unsigned idx;
    if (w.op == OP_SEED) begin
      reseed_table(w.seed);
    end else begin
      if (draw_total != '1) begin
        draw_total = draw_total + 1;
      end
      if (draw_limit != '0 && draw_total > draw_limit) begin
        res.value = '0;
        res.flagged = 1'b1;
      end else begin
        gen_state = park_miller_next(gen_state);
        slot_div = (32'd2147483646 / DEPTH) + 1;
        idx = last_pick / slot_div;
        if (idx >= DEPTH) begin
          idx = DEPTH - 1;
        end
        res.value = slots[idx];
        res.flagged = 1'b0;
        slots[idx] = gen_state;
        last_pick = res.value;
      end
      draws_due.push_back(res);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        step_rng_model('{op: in_operation, seed: in_seed_value});
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (words_to_send.size() > 0 && (steady_phase || $urandom_range(0, 99) >= 6)) begin
          rng_word_t w;
          w = words_to_send.pop_front();
          in_valid <= 1'b1;
          in_operation <= w.op;
          in_seed_value <= w.seed;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (draws_due.size() == 0) begin
          $error("unexpected out word: random_value %0d limit_reached %0b",
                 out_random_value, out_limit_reached);
          errors++;
        end else begin
          draw_result_t exp_res;
          exp_res = draws_due.pop_front();
          if (out_random_value !== exp_res.value) begin
            $error("random_value: expected %0d, got %0d", exp_res.value, out_random_value);
            errors++;
          end
          if (out_limit_reached !== exp_res.flagged) begin
            $error("limit_reached: expected %0b, got %0b", exp_res.flagged,
                   out_limit_reached);
            errors++;
          end
          if (exp_res.flagged) begin
            flagged_seen++;
          end
        end
        draws_checked++;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready && (draws_checked == 150 || draws_checked == 800)) begin
        // long back-pressure so the core fills and stalls its input
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady_phase || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("shuffled_minimal_standard_rng_core regression: fail");
      $finish;
    end
  end

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return {1'b0, SEED_CAP} - 32'($urandom_range(0, 2)) + 32'($urandom_range(0, 2));
      2: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
      3: return 32'h8000_0000 | 32'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_word(logic op, logic [31:0] seed);
    words_to_send.push_back('{op: op, seed: seed});
    if (op == OP_SEED) begin
      reseeds_sent++;
    end
  endtask

  // mostly runs of draws, broken now and then by a reseed
  task automatic queue_random_words(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        queue_word(OP_SEED, pick_seed());
      end else begin
        queue_word(OP_DRAW, $urandom);
      end
    end
  endtask

  task automatic wait_idle();
    while (words_to_send.size() != 0 || in_valid || draws_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(cnt_t value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    draw_limit = value;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_limit(32'hFFFF_FFFF);
    // seed corner cases; a reseed always comes before the first draw
    queue_word(OP_SEED, 32'h0);
    repeat (3) queue_word(OP_DRAW, 32'h0);
    queue_word(OP_SEED, 32'hFFFF_FFFF);
    repeat (2) queue_word(OP_DRAW, 32'hFFFF_FFFF);
    queue_word(OP_SEED, {1'b0, SEED_CAP});
    repeat (3) queue_word(OP_DRAW, 32'h5555_5555);
    queue_word(OP_SEED, {1'b0, SEED_CAP} + 32'd1);
    queue_word(OP_DRAW, 32'hAAAA_AAAA);
    queue_word(OP_SEED, 32'h8000_0005);
    repeat (2) queue_word(OP_DRAW, 32'h0);
    queue_word(OP_SEED, 32'h1);
    repeat (3) queue_word(OP_DRAW, 32'h0);
    queue_word(OP_SEED, 32'd12345);
    queue_word(OP_SEED, 32'd42);
    repeat (2) queue_word(OP_DRAW, 32'h0);
    wait_idle();

    write_limit('0);
    queue_random_words(450);
    wait_idle();

    // limit a little above the count: later draws get flagged
    write_limit(draw_total + 20);
    queue_random_words(150);
    wait_idle();

    steady_phase = 1'b1;
    write_limit(LIMIT_RESET);
    queue_random_words(400);
    wait_idle();
    steady_phase = 1'b0;

    write_limit(32'd1);
    queue_random_words(60);
    wait_idle();

    write_limit(draw_total + 32'($urandom_range(10, 100)));
    queue_random_words(250);
    wait_idle();

    $display("sent %0d words (%0d reseeds), checked %0d draws, %0d flagged over the limit",
             words_sent, reseeds_sent, draws_checked, flagged_seen);
    if (errors == 0 && draws_due.size() == 0) begin
      $display("shuffled_minimal_standard_rng_core regression: pass");
    end else begin
      $display("shuffled_minimal_standard_rng_core regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
